### sv/asp_pkg.sv
// Shared types, codes and type-range helpers for the ASCII scalar parser.
`default_nettype none
package asp_pkg;

	localparam logic [7:0] MaxNode = 8'd127;

	typedef enum logic [2:0] {
		TY_BOOL = 3'd0,
		TY_U8   = 3'd1,
		TY_U16  = 3'd2,
		TY_U32  = 3'd3,
		TY_I8   = 3'd4,
		TY_I16  = 3'd5,
		TY_I32  = 3'd6,
		TY_NODE = 3'd7
	} scalar_t;

	typedef enum logic [4:0] {
		PH_START  = 5'b00001,
		PH_MINUS  = 5'b00010,
		PH_PLUS   = 5'b00100,
		PH_ZERO   = 5'b01000,
		PH_DIGITS = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [31:0] acc;
		phase_t      phase;
		logic        hex;
		logic        seen;
		logic        neg;
		logic        err;
	} parse_t;

	localparam parse_t ParseReset = '{
		acc: 32'd0, phase: PH_START, hex: 1'b0, seen: 1'b0, neg: 1'b0, err: 1'b0
	};

	function automatic logic type_signed(scalar_t t);
		return (t == TY_I8) || (t == TY_I16) || (t == TY_I32);
	endfunction

	function automatic logic [2:0] type_bytes(scalar_t t);
		logic [2:0] b;
		unique case (t) inside
			TY_U16, TY_I16: b = 3'd2;
			TY_U32, TY_I32: b = 3'd4;
			default:        b = 3'd1;
		endcase
		return b;
	endfunction

	// Largest magnitude allowed; negative side is one larger.
	function automatic logic [31:0] type_max(scalar_t t, logic neg);
		logic [31:0] m;
		unique case (t)
			TY_BOOL: m = 32'd1;
			TY_U8:   m = 32'h0000_00ff;
			TY_U16:  m = 32'h0000_ffff;
			TY_U32:  m = 32'hffff_ffff;
			TY_I8:   m = neg ? 32'h0000_0080 : 32'h0000_007f;
			TY_I16:  m = neg ? 32'h0000_8000 : 32'h0000_7fff;
			TY_I32:  m = neg ? 32'h8000_0000 : 32'h7fff_ffff;
			default: m = {24'd0, MaxNode};
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

### sv/asp_step.sv
// Per-character update of the parse state: sign, prefix, digit accumulate and range check.
`default_nettype none
module asp_step (
	input  asp_pkg::parse_t  cur,
	input  logic [7:0]       ch,
	input  asp_pkg::scalar_t styp,
	output asp_pkg::parse_t  nxt
);
	import asp_pkg::*;

	localparam logic [7:0] ChMinus = 8'h2d;
	localparam logic [7:0] ChPlus  = 8'h2b;
	localparam logic [7:0] Ch0     = 8'h30;
	localparam logic [7:0] Ch9     = 8'h39;
	localparam logic [7:0] ChLa    = 8'h61;
	localparam logic [7:0] ChLf    = 8'h66;
	localparam logic [7:0] ChUa    = 8'h41;
	localparam logic [7:0] ChUf    = 8'h46;
	localparam logic [7:0] ChLx    = 8'h78;
	localparam logic [7:0] ChUx    = 8'h58;
	localparam logic [7:0] LowOff  = 8'h57;
	localparam logic [7:0] UpOff   = 8'h37;

	logic        is_dec, is_lo, is_up, dig_ok;
	logic [7:0]  dsub;
	logic [3:0]  dval;
	logic [35:0] acc_w, prod, next_val;
	logic        in_range;
	logic        do_add;
	logic        body;
	parse_t      pre;

	// Digit decode and multiply-add use the hex flag as it stands before this character.
	always_comb begin
		is_dec = (ch >= Ch0) && (ch <= Ch9);
		is_lo  = cur.hex && (ch >= ChLa) && (ch <= ChLf);
		is_up  = cur.hex && (ch >= ChUa) && (ch <= ChUf);
		dig_ok = is_dec || is_lo || is_up;
		if (is_lo) begin
			dsub = ch - LowOff;
		end else if (is_up) begin
			dsub = ch - UpOff;
		end else begin
			dsub = ch - Ch0;
		end
		dval     = dsub[3:0];
		acc_w    = {4'd0, cur.acc};
		prod     = cur.hex ? (acc_w << 4) : ((acc_w << 3) + (acc_w << 1));
		next_val = prod + {32'd0, dval};
		in_range = next_val <= {4'd0, type_max(styp, cur.neg)};
	end

	always_comb begin
		pre    = cur;
		do_add = 1'b0;
		body   = 1'b0;
		if (!cur.err) begin
			unique case (cur.phase)
				PH_START: begin
					if (ch == ChMinus) begin
						if (type_signed(styp)) begin
							pre.neg   = 1'b1;
							pre.phase = PH_MINUS;
						end else begin
							pre.err = 1'b1;
						end
					end else if (ch == ChPlus) begin
						pre.phase = PH_PLUS;
					end else begin
						body = 1'b1;
					end
				end
				PH_MINUS: begin
					if (ch == ChPlus) begin
						pre.phase = PH_PLUS;
					end else begin
						body = 1'b1;
					end
				end
				PH_PLUS: body = 1'b1;
				PH_ZERO: begin
					pre.phase = PH_DIGITS;
					if ((ch == ChLx) || (ch == ChUx)) begin
						pre.hex  = 1'b1;
						pre.seen = 1'b0;
						pre.acc  = 32'd0;
					end else begin
						do_add = 1'b1;
					end
				end
				PH_DIGITS: do_add = 1'b1;
				default: pre.err = 1'b1;
			endcase
		end
		if (body) begin
			pre.phase = (ch == Ch0) ? PH_ZERO : PH_DIGITS;
			do_add    = 1'b1;
		end
		nxt = pre;
		if (do_add) begin
			if (!dig_ok || !in_range) begin
				nxt.err = 1'b1;
			end else begin
				nxt.acc  = next_val[31:0];
				nxt.seen = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### sv/asp_encode.sv
// Final result formation: ok flag, sign apply, byte mask and byte count.
`default_nettype none
module asp_encode (
	input  asp_pkg::parse_t  fin,
	input  asp_pkg::scalar_t styp,
	output logic             ok,
	output logic [31:0]      value,
	output logic [2:0]       bytes
);
	import asp_pkg::*;

	logic [31:0] raw;

	always_comb begin
		bytes = type_bytes(styp);
		ok    = !fin.err && fin.seen && !((styp == TY_NODE) && (fin.acc == 32'd0));
		raw   = fin.neg ? (32'd0 - fin.acc) : fin.acc;
		if (bytes == 3'd1) begin
			raw = {24'd0, raw[7:0]};
		end else if (bytes == 3'd2) begin
			raw = {16'd0, raw[15:0]};
		end
		value = ok ? raw : 32'd0;
	end

endmodule
`default_nettype wire

### sv/ascii_scalar_parser.sv
// Top level of the ASCII scalar parser: input register, parse state, result register.
//
//   channel  direction  handshake            payload
//   in       request in in_valid / in_stall  text_char, last_char
//   out      request out out_valid/out_stall parse_ok, encoded_value, byte_count
//   cfg      write only cfg_we               cfg_data (scalar type)
//
// One character per cycle while in_stall is low; a request is held in the input register,
// and a result is registered as the last character leaves that register.
// Reset clears the parse state and sets the scalar type to u32.
// A stalled result holds the output register; only a last character then waits,
// which stalls the input side, while other characters keep flowing.
`default_nettype none
module ascii_scalar_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  text_char,
	input  wire logic        last_char,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             parse_ok,
	output logic [31:0]      encoded_value,
	output logic [2:0]       byte_count
);
	import asp_pkg::*;

	scalar_t     type_q;
	parse_t      st_q, st_nxt;
	logic        valid_s1, last_s1;
	logic [7:0]  char_s1;
	logic        valid_s2, ok_s2;
	logic [31:0] value_s2;
	logic [2:0]  bytes_s2;
	logic        s2_free, adv, accept;
	logic        enc_ok;
	logic [31:0] enc_value;
	logic [2:0]  enc_bytes;

	assign s2_free  = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && (!last_s1 || s2_free);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	asp_step u_step (
		.cur  (st_q),
		.ch   (char_s1),
		.styp (type_q),
		.nxt  (st_nxt)
	);

	asp_encode u_encode (
		.fin   (st_nxt),
		.styp  (type_q),
		.ok    (enc_ok),
		.value (enc_value),
		.bytes (enc_bytes)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q   <= TY_U32;
			st_q     <= ParseReset;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				type_q <= scalar_t'(cfg_data);
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			// Start a fresh text after the last character.
			if (adv) begin
				st_q <= last_s1 ? ParseReset : st_nxt;
			end
			if (adv && last_s1) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= text_char;
			last_s1 <= last_char;
		end
		if (adv && last_s1) begin
			ok_s2    <= enc_ok;
			value_s2 <= enc_value;
			bytes_s2 <= enc_bytes;
		end
	end

	assign out_valid     = valid_s2;
	assign parse_ok      = ok_s2;
	assign encoded_value = value_s2;
	assign byte_count    = bytes_s2;

endmodule
`default_nettype wire
